// ===== rtl/core/gra_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the grid run allocator
// no dependencies

package gra_pkg;

    localparam int MAX_ROWS   = 32;
    localparam int MAX_COLS   = 128;
    localparam int OWNER_BITS = 16;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int LEN_W      = 8;
    localparam int CNT_W      = 13;
    localparam int NR_W       = 6;
    localparam int ADDR_W     = ROW_W + COL_W;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [2:0] {
        OP_CLAIM_AT    = 3'd0,
        OP_CLAIM_FIRST = 3'd1,
        OP_FREE_AT     = 3'd2,
        OP_FREE_OWNER  = 3'd3,
        OP_FREE_ALL    = 3'd4,
        OP_QUERY_AT    = 3'd5,
        OP_ROW_RUNS    = 3'd6,
        OP_STATS       = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_RDW,
        S_SCAN,
        S_OWN,
        S_FILL,
        S_WB,
        S_NEXT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0]            operation;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [LEN_W-1:0]      run_length;
        logic [OWNER_BITS-1:0] owner;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ROW_W-1:0] found_row;
        logic [COL_W-1:0] first_col;
        logic [COL_W-1:0] end_col;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] free_count;
        logic [LEN_W-1:0] longest_run;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic                  tk_we;
        logic [ROW_W-1:0]      tk_addr;
        logic [MAX_COLS-1:0]   tk_wdata;
        logic                  ow_we;
        logic [ADDR_W-1:0]     ow_addr;
        logic [OWNER_BITS-1:0] ow_wdata;
    } store_req_t;

endpackage

// ===== rtl/core/grid_run_allocator_core.sv =====
`timescale 1ns / 1ps
// grid run allocator: slot grid of rows by columns with taken bits and owner tags
// depends on gra_pkg and gra_store
//
// usage
// - req channel (valid/ready) carries one operation per transaction; req_ready is
//   high only while the block is idle, one operation is worked at a time
// - rsp channel (valid/ready) returns one result per operation, several for
//   row_runs; the final result of an operation has last set
// - cfg channel writes rows_in_use (index 0) and cols_in_use (index 1); write
//   only while idle, cfg_ready is always high
// - run time follows the column walk: every scanned row costs a row read, a
//   step per column and a write-back where the operation may change the row;
//   free_owner adds an owner memory read on each taken slot. single-slot
//   operations read one row, claims add a check and a fill step per claimed
//   slot, and whole-grid scans walk every column of every row in use
// - a finished result sits in an output register, so the next operation is
//   accepted while it waits; a stalled receiver holds the block only when a
//   further result is ready to go
// - reset clears all taken bits at once through per-row valid bits, so no
//   clearing pass is needed; registers return to 32 rows and 128 columns

module grid_run_allocator_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  gra_pkg::in_item_t    req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output gra_pkg::out_item_t   rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data
);
    import gra_pkg::*;

    state_t                state_reg, state_next, ret_reg, ret_next;
    op_t                   op_reg, op_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [OWNER_BITS-1:0] own_reg, own_next;
    logic [ROW_W-1:0]      r_reg, r_next;
    logic [COL_W-1:0]      c_reg, c_next;
    logic [LEN_W-1:0]      run_reg, run_next;
    logic [LEN_W-1:0]      best_reg, best_next;
    logic [ROW_W-1:0]      brow_reg, brow_next;
    logic [COL_W-1:0]      start_reg, start_next;
    logic [COL_W-1:0]      end_reg, end_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      free_reg, free_next;
    logic [MAX_COLS-1:0]   word_reg, word_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [ROW_W-1:0]      pend_row_reg, pend_row_next;
    logic [LEN_W-1:0]      pend_long_reg, pend_long_next;
    out_item_t             res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;
    logic [NR_W-1:0]       rows_reg;
    logic [LEN_W-1:0]      cols_reg;

    store_req_t            sreq;
    logic [MAX_COLS-1:0]   tk_rdata;
    logic [OWNER_BITS-1:0] ow_rdata;

    logic [NR_W-1:0]       nr;
    logic [LEN_W-1:0]      nc;
    logic                  last_col, last_row, bit_taken, slot_free, addr_ok;
    logic [LEN_W-1:0]      run_inc, row_best;
    logic [LEN_W:0]        claim_end;

    gra_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (sreq),
        .tk_rdata (tk_rdata),
        .ow_rdata (ow_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= NR_W'(MAX_ROWS);
            cols_reg <= LEN_W'(MAX_COLS);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data[NR_W-1:0];
                CFG_COLS: cols_reg <= cfg_data;
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (rows_reg == '0)
            nr = NR_W'(1);
        else if (rows_reg > NR_W'(MAX_ROWS))
            nr = NR_W'(MAX_ROWS);
        else
            nr = rows_reg;
        if (cols_reg == '0)
            nc = LEN_W'(1);
        else if (cols_reg > LEN_W'(MAX_COLS))
            nc = LEN_W'(MAX_COLS);
        else
            nc = cols_reg;
    end

    assign last_col  = ({1'b0, c_reg} == (nc - LEN_W'(1)));
    assign last_row  = ({1'b0, r_reg} == (nr - NR_W'(1)));
    assign bit_taken = word_reg[c_reg];
    assign run_inc   = run_reg + LEN_W'(1);
    assign row_best  = (!bit_taken && run_inc > best_reg) ? run_inc : best_reg;
    assign slot_free = !out_valid_reg || rsp_ready;
    assign addr_ok   = ({1'b0, req.row} < nr) && ({1'b0, req.col} < nc);
    assign claim_end = {2'b00, req.col} + {1'b0, req.run_length};

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        sreq.tk_we    = (state_reg == S_WB);
        sreq.tk_addr  = r_reg;
        sreq.tk_wdata = word_reg;
        sreq.ow_we    = (state_reg == S_FILL);
        sreq.ow_addr  = {r_reg, c_reg};
        sreq.ow_wdata = own_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        col_reg       <= col_next;
        len_reg       <= len_next;
        own_reg       <= own_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        run_reg       <= run_next;
        best_reg      <= best_next;
        brow_reg      <= brow_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        cnt_reg       <= cnt_next;
        free_reg      <= free_next;
        word_reg      <= word_next;
        pend_row_reg  <= pend_row_next;
        pend_long_reg <= pend_long_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        op_next         = op_reg;
        col_next        = col_reg;
        len_next        = len_reg;
        own_next        = own_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        run_next        = run_reg;
        best_next       = best_reg;
        brow_next       = brow_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        cnt_next        = cnt_reg;
        free_next       = free_reg;
        word_next       = word_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_long_next  = pend_long_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = op_t'(req.operation);
                    col_next        = req.col;
                    len_next        = req.run_length;
                    own_next        = req.owner;
                    run_next        = '0;
                    best_next       = '0;
                    brow_next       = '0;
                    cnt_next        = '0;
                    free_next       = '0;
                    pend_valid_next = 1'b0;
                    r_next          = '0;
                    c_next          = '0;
                    res_next        = '0;
                    res_next.last   = 1'b1;
                    res_next.status = ST_BAD;
                    ret_next        = S_IDLE;
                    state_next      = S_RD;
                    case (op_t'(req.operation))
                        OP_CLAIM_AT:
                        begin
                            r_next     = req.row;
                            c_next     = req.col;
                            start_next = req.col;
                            end_next   = COL_W'(claim_end - 9'd1);
                            if (!addr_ok || req.run_length == '0 ||
                                claim_end > {1'b0, nc})
                                state_next = S_EMIT;
                        end
                        OP_FREE_AT, OP_QUERY_AT:
                        begin
                            r_next = req.row;
                            c_next = req.col;
                            if (!addr_ok)
                                state_next = S_EMIT;
                        end
                        OP_CLAIM_FIRST, OP_ROW_RUNS:
                        begin
                            if (req.run_length == '0)
                                state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_RD;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                state_next = S_RDW;
            end

            S_RDW:
            begin
                word_next  = tk_rdata;
                run_next   = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                res_next      = '0;
                res_next.last = 1'b1;
                ret_next      = S_IDLE;
                case (op_reg)
                    OP_CLAIM_AT:
                    begin
                        if (bit_taken)
                        begin
                            res_next.status = ST_BUSY;
                            state_next      = S_EMIT;
                        end
                        else if (c_reg == end_reg)
                        begin
                            c_next     = start_reg;
                            state_next = S_FILL;
                        end
                        else
                            c_next = c_reg + COL_W'(1);
                    end
                    OP_CLAIM_FIRST:
                    begin
                        run_next = bit_taken ? '0 : run_inc;
                        if (!bit_taken && run_inc == len_reg)
                        begin
                            start_next = c_reg - len_reg[COL_W-1:0] + COL_W'(1);
                            end_next   = c_reg;
                            c_next     = c_reg - len_reg[COL_W-1:0] + COL_W'(1);
                            state_next = S_FILL;
                        end
                        else if (last_col)
                            state_next = S_NEXT;
                        else
                            c_next = c_reg + COL_W'(1);
                    end
                    OP_FREE_AT:
                    begin
                        if (bit_taken)
                        begin
                            word_next[c_reg] = 1'b0;
                            state_next       = S_WB;
                        end
                        else
                        begin
                            res_next.status = ST_BUSY;
                            state_next      = S_EMIT;
                        end
                    end
                    OP_QUERY_AT:
                    begin
                        res_next.status    = bit_taken ? ST_BUSY : ST_OK;
                        res_next.found_row = r_reg;
                        res_next.first_col = c_reg;
                        res_next.end_col   = c_reg;
                        state_next         = S_EMIT;
                    end
                    OP_FREE_OWNER, OP_FREE_ALL:
                    begin
                        if (bit_taken && op_reg == OP_FREE_OWNER)
                            state_next = S_OWN;
                        else
                        begin
                            if (bit_taken)
                            begin
                                word_next[c_reg] = 1'b0;
                                cnt_next         = cnt_reg + CNT_W'(1);
                            end
                            if (last_col)
                                state_next = S_WB;
                            else
                                c_next = c_reg + COL_W'(1);
                        end
                    end
                    OP_ROW_RUNS:
                    begin
                        run_next  = bit_taken ? '0 : run_inc;
                        best_next = row_best;
                        if (last_col)
                        begin
                            state_next = S_NEXT;
                            if (row_best >= len_reg)
                            begin
                                pend_valid_next = 1'b1;
                                pend_row_next   = r_reg;
                                pend_long_next  = row_best;
                                // earlier listed row goes out, it is not the final one
                                if (pend_valid_reg)
                                begin
                                    res_next.found_row   = pend_row_reg;
                                    res_next.longest_run = pend_long_reg;
                                    res_next.last        = 1'b0;
                                    ret_next             = S_NEXT;
                                    state_next           = S_EMIT;
                                end
                            end
                        end
                        else
                            c_next = c_reg + COL_W'(1);
                    end
                    default:
                    begin
                        if (bit_taken)
                        begin
                            cnt_next = cnt_reg + CNT_W'(1);
                            run_next = '0;
                        end
                        else
                        begin
                            free_next = free_reg + CNT_W'(1);
                            run_next  = run_inc;
                            if (run_inc > best_reg)
                            begin
                                best_next = run_inc;
                                brow_next = r_reg;
                            end
                        end
                        if (last_col)
                            state_next = S_NEXT;
                        else
                            c_next = c_reg + COL_W'(1);
                    end
                endcase
            end

            S_OWN:
            begin
                if (ow_rdata == own_reg)
                begin
                    word_next[c_reg] = 1'b0;
                    cnt_next         = cnt_reg + CNT_W'(1);
                end
                if (last_col)
                    state_next = S_WB;
                else
                begin
                    c_next     = c_reg + COL_W'(1);
                    state_next = S_SCAN;
                end
            end

            S_FILL:
            begin
                word_next[c_reg] = 1'b1;
                if (c_reg == end_reg)
                    state_next = S_WB;
                else
                    c_next = c_reg + COL_W'(1);
            end

            S_WB:
            begin
                res_next      = '0;
                res_next.last = 1'b1;
                ret_next      = S_IDLE;
                case (op_reg)
                    OP_CLAIM_AT, OP_CLAIM_FIRST:
                    begin
                        res_next.found_row = r_reg;
                        res_next.first_col = start_reg;
                        res_next.end_col   = end_reg;
                        state_next         = S_EMIT;
                    end
                    OP_FREE_AT:
                    begin
                        res_next.count = CNT_W'(1);
                        state_next     = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_NEXT;
                    end
                endcase
            end

            S_NEXT:
            begin
                if (last_row)
                begin
                    res_next      = '0;
                    res_next.last = 1'b1;
                    ret_next      = S_IDLE;
                    state_next    = S_EMIT;
                    case (op_reg)
                        OP_FREE_OWNER, OP_FREE_ALL:
                        begin
                            res_next.status = (cnt_reg == '0) ? ST_BUSY : ST_OK;
                            res_next.count  = cnt_reg;
                        end
                        OP_ROW_RUNS:
                        begin
                            if (pend_valid_reg)
                            begin
                                res_next.found_row   = pend_row_reg;
                                res_next.longest_run = pend_long_reg;
                            end
                            else
                                res_next.status = ST_BUSY;
                        end
                        OP_STATS:
                        begin
                            res_next.found_row   = brow_reg;
                            res_next.count       = cnt_reg;
                            res_next.free_count  = free_reg;
                            res_next.longest_run = best_reg;
                        end
                        default:
                        begin
                            res_next.status = ST_BUSY;
                        end
                    endcase
                end
                else
                begin
                    r_next     = r_reg + ROW_W'(1);
                    c_next     = '0;
                    run_next   = '0;
                    if (op_reg == OP_ROW_RUNS)
                        best_next = '0;
                    state_next = S_RD;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/gra_store.sv =====
`timescale 1ns / 1ps
// taken bitmap (one word per row, per-row valid bits) and owner tag memory
// depends on gra_pkg

module gra_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gra_pkg::store_req_t            req,
    output logic [gra_pkg::MAX_COLS-1:0]   tk_rdata,
    output logic [gra_pkg::OWNER_BITS-1:0] ow_rdata
);
    import gra_pkg::*;

    logic [MAX_COLS-1:0]   tk_mem [MAX_ROWS];
    logic [OWNER_BITS-1:0] ow_mem [MAX_ROWS*MAX_COLS];
    logic [MAX_ROWS-1:0]   row_valid_reg;
    logic                  rvalid_reg;
    logic [MAX_COLS-1:0]   tk_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.tk_we)
        begin
            tk_mem[req.tk_addr] <= req.tk_wdata;
        end
        tk_data_reg <= tk_mem[req.tk_addr];
    end

    // a row never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (req.tk_we)
            begin
                row_valid_reg[req.tk_addr] <= 1'b1;
            end
            rvalid_reg <= row_valid_reg[req.tk_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ow_we)
        begin
            ow_mem[req.ow_addr] <= req.ow_wdata;
        end
        ow_rdata <= ow_mem[req.ow_addr];
    end

    assign tk_rdata = rvalid_reg ? tk_data_reg : '0;

endmodule

// ===== rtl/core/gra_checker.sv =====
`timescale 1ns / 1ps
// port-level checks on the grid run allocator request and result channels
// depends on gra_pkg; bound to grid_run_allocator_core

module gra_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input gra_pkg::out_item_t  rsp
);
    import gra_pkg::*;

    // a stalled transaction keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // errors always close the operation (last set) and report a zero count
    a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_BAD |-> rsp.last && rsp.count == '0)
        else $error("error result malformed");

    // only listed rows come as non-final results
    a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.status == ST_OK && rsp.longest_run != '0)
        else $error("unexpected non-final result");

    // one operation at a time: no new request taken in the cycle after one
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind grid_run_allocator_core gra_checker u_gra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for grid_run_allocator_core: directed table, then random phases over several grid sizes
// depends on gra_pkg and the core; results are checked against an in-bench grid predictor

module tb_top;
    import gra_pkg::*;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    in_item_t  req;
    logic      rsp_valid;
    logic      rsp_ready;
    out_item_t rsp;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [7:0] cfg_data;

    // grid shadow and register copies
    bit                    grid_taken [MAX_ROWS][MAX_COLS];
    logic [OWNER_BITS-1:0] grid_owner [MAX_ROWS][MAX_COLS];
    int unsigned           rows_reg;
    int unsigned           cols_reg;

    out_item_t pending_rsp[$];
    dir_row_t  dir_tab[$];
    int        mismatches;
    int        idle_mode;
    bit        hold_request;

    grid_run_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned area_rows();
        return (rows_reg < 1) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    endfunction

    function automatic int unsigned area_cols();
        return (cols_reg < 1) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
    endfunction

    function automatic out_item_t mk(int st, int r, int fc, int ec, int cnt, int fr, int lg);
        out_item_t o;
        o.status      = 2'(st);
        o.found_row   = ROW_W'(r);
        o.first_col   = COL_W'(fc);
        o.end_col     = COL_W'(ec);
        o.count       = CNT_W'(cnt);
        o.free_count  = CNT_W'(fr);
        o.longest_run = LEN_W'(lg);
        o.last        = 1'b1;
        return o;
    endfunction

    // works out the results of one operation and updates the grid shadow
    function automatic void predict_grid_op(in_item_t it);
        out_item_t   o;
        out_item_t   listed[$];
        int unsigned nr, nc, r, c, n, best, brow, taken_n, free_n, s, len;
        bit          addr_ok, hit;
        nr      = area_rows();
        nc      = area_cols();
        len     = it.run_length;
        addr_ok = (it.row < nr) && (it.col < nc);
        o       = '0;
        o.last  = 1'b1;
        case (op_t'(it.operation))
            OP_CLAIM_AT:
            begin
                if (!addr_ok || len == 0 || it.col + len > nc)
                    o.status = ST_BAD;
                else
                begin
                    hit = 0;
                    for (c = it.col; c < it.col + len; c++)
                        if (grid_taken[it.row][c]) hit = 1;
                    if (hit)
                        o.status = ST_BUSY;
                    else
                    begin
                        for (c = it.col; c < it.col + len; c++)
                        begin
                            grid_taken[it.row][c] = 1;
                            grid_owner[it.row][c] = it.owner;
                        end
                        o = mk(ST_OK, it.row, it.col, it.col + len - 1, 0, 0, 0);
                    end
                end
                pending_rsp.push_back(o);
            end
            OP_CLAIM_FIRST:
            begin
                if (len == 0)
                    o.status = ST_BAD;
                else
                begin
                    o.status = ST_BUSY;
                    hit = 0;
                    for (r = 0; r < nr && !hit; r++)
                    begin
                        n = 0;
                        for (c = 0; c < nc && !hit; c++)
                        begin
                            if (grid_taken[r][c])
                                n = 0;
                            else
                            begin
                                n++;
                                if (n == len)
                                begin
                                    s = c + 1 - len;
                                    for (int k = s; k <= c; k++)
                                    begin
                                        grid_taken[r][k] = 1;
                                        grid_owner[r][k] = it.owner;
                                    end
                                    o = mk(ST_OK, r, s, c, 0, 0, 0);
                                    hit = 1;
                                end
                            end
                        end
                    end
                end
                pending_rsp.push_back(o);
            end
            OP_FREE_AT:
            begin
                if (!addr_ok)
                    o.status = ST_BAD;
                else if (grid_taken[it.row][it.col])
                begin
                    grid_taken[it.row][it.col] = 0;
                    o.count = CNT_W'(1);
                end
                else
                    o.status = ST_BUSY;
                pending_rsp.push_back(o);
            end
            OP_FREE_OWNER, OP_FREE_ALL:
            begin
                n = 0;
                for (r = 0; r < nr; r++)
                    for (c = 0; c < nc; c++)
                        if (grid_taken[r][c] && (op_t'(it.operation) == OP_FREE_ALL
                                                  || grid_owner[r][c] == it.owner))
                        begin
                            grid_taken[r][c] = 0;
                            n++;
                        end
                o.status = (n != 0) ? ST_OK : ST_BUSY;
                o.count  = CNT_W'(n);
                pending_rsp.push_back(o);
            end
            OP_QUERY_AT:
            begin
                if (!addr_ok)
                    o.status = ST_BAD;
                else
                    o = mk(grid_taken[it.row][it.col] ? ST_BUSY : ST_OK, it.row, it.col,
                           it.col, 0, 0, 0);
                pending_rsp.push_back(o);
            end
            OP_ROW_RUNS:
            begin
                if (len == 0)
                begin
                    o.status = ST_BAD;
                    pending_rsp.push_back(o);
                end
                else
                begin
                    for (r = 0; r < nr; r++)
                    begin
                        n = 0;
                        best = 0;
                        for (c = 0; c < nc; c++)
                        begin
                            n = grid_taken[r][c] ? 0 : n + 1;
                            if (n > best) best = n;
                        end
                        if (best >= len)
                        begin
                            o = mk(ST_OK, r, 0, 0, 0, 0, best);
                            o.last = 1'b0;
                            listed.push_back(o);
                        end
                    end
                    if (listed.size() == 0)
                        listed.push_back(mk(ST_BUSY, 0, 0, 0, 0, 0, 0));
                    listed[listed.size() - 1].last = 1'b1;
                    foreach (listed[i]) pending_rsp.push_back(listed[i]);
                end
            end
            default:
            begin
                taken_n = 0;
                free_n  = 0;
                best    = 0;
                brow    = 0;
                for (r = 0; r < nr; r++)
                begin
                    n = 0;
                    for (c = 0; c < nc; c++)
                    begin
                        if (grid_taken[r][c])
                        begin
                            taken_n++;
                            n = 0;
                        end
                        else
                        begin
                            free_n++;
                            n++;
                            if (n > best)
                            begin
                                best = n;
                                brow = r;
                            end
                        end
                    end
                end
                pending_rsp.push_back(mk(ST_OK, brow, 0, 0, taken_n, free_n, best));
            end
        endcase
    endfunction

    function automatic in_item_t mk_item(op_t op, int r, int c, int len, int own);
        in_item_t it;
        it.operation  = op;
        it.row        = ROW_W'(r);
        it.col        = COL_W'(c);
        it.run_length = LEN_W'(len);
        it.owner      = OWNER_BITS'(own);
        return it;
    endfunction

    function automatic void add_row(in_item_t it, bit typed, out_item_t want);
        dir_row_t d;
        d.item  = it;
        d.typed = typed;
        d.want  = want;
        dir_tab.push_back(d);
    endfunction

    function automatic in_item_t rand_item();
        in_item_t    it;
        int unsigned nr, nc, pick;
        logic [15:0] owner_pool[4];
        nr = area_rows();
        nc = area_cols();
        owner_pool = '{16'h0001, 16'h00a5, 16'h8000, 16'hffff};
        pick = $urandom_range(0, 99);
        if (pick < 25)      it.operation = OP_CLAIM_AT;
        else if (pick < 50) it.operation = OP_CLAIM_FIRST;
        else if (pick < 65) it.operation = OP_FREE_AT;
        else if (pick < 70) it.operation = OP_FREE_OWNER;
        else if (pick < 73) it.operation = OP_FREE_ALL;
        else if (pick < 83) it.operation = OP_QUERY_AT;
        else if (pick < 90) it.operation = OP_ROW_RUNS;
        else                it.operation = OP_STATS;
        // mostly inside the area, with the odd address just past or anywhere
        it.row = ROW_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, nr));
        it.col = COL_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, nc));
        it.run_length = LEN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(1, nc / 2 + 1));
        it.owner = ($urandom_range(0, 4) == 0) ? OWNER_BITS'($urandom)
                                               : owner_pool[$urandom_range(0, 3)];
        return it;
    endfunction

    task automatic send_op(in_item_t it);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 51 : ((idle_mode == 3) ? 14 : 0);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do @(posedge clk); while (!req_ready);
    endtask

    // leaves cfg_valid high; the caller drops it after its last write
    task automatic write_reg(logic idx, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_ROWS) rows_reg = data & 8'h3f;
        else                 cols_reg = data;
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // result side: checks each transaction and drives ready
    always @(posedge clk)
    begin
        out_item_t want;
        int        stall_pct;
        int        hold_left;
        bit        hold_done;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result with no operation outstanding: %p", rsp);
                mismatches++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatches++;
                end
                if (rsp.found_row !== want.found_row)
                begin
                    $error("found_row: expected %0d, got %0d", want.found_row, rsp.found_row);
                    mismatches++;
                end
                if (rsp.first_col !== want.first_col)
                begin
                    $error("first_col: expected %0d, got %0d", want.first_col, rsp.first_col);
                    mismatches++;
                end
                if (rsp.end_col !== want.end_col)
                begin
                    $error("end_col: expected %0d, got %0d", want.end_col, rsp.end_col);
                    mismatches++;
                end
                if (rsp.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, rsp.count);
                    mismatches++;
                end
                if (rsp.free_count !== want.free_count)
                begin
                    $error("free_count: expected %0d, got %0d", want.free_count,
                           rsp.free_count);
                    mismatches++;
                end
                if (rsp.longest_run !== want.longest_run)
                begin
                    $error("longest_run: expected %0d, got %0d", want.longest_run,
                           rsp.longest_run);
                    mismatches++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp.last);
                    mismatches++;
                end
            end
        end
        if (hold_request && !hold_done)
        begin
            hold_left = 300;
            hold_done = 1;
        end
        stall_pct = (idle_mode == 2) ? 51 : ((idle_mode == 3) ? 14 : 0);
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        int phase_rows[8];
        int phase_cols[8];
        int phase_items[8];
        int phase_mode[8];
        in_item_t it;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_ROWS;
        cfg_data     = '0;
        mismatches   = 0;
        idle_mode    = 0;
        hold_request = 0;
        rows_reg     = 32;
        cols_reg     = 128;
        foreach (grid_taken[r, c])
        begin
            grid_taken[r][c] = 0;
            grid_owner[r][c] = '0;
        end

        // directed part on the full 32 by 128 grid after reset
        add_row(mk_item(OP_STATS, 0, 0, 1, 0), 1, mk(ST_OK, 0, 0, 0, 0, 4096, 128));
        add_row(mk_item(OP_QUERY_AT, 0, 0, 1, 0), 1, mk(ST_OK, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_CLAIM_AT, 31, 127, 1, 16'hffff), 1,
                mk(ST_OK, 31, 127, 127, 0, 0, 0));
        add_row(mk_item(OP_CLAIM_AT, 0, 0, 0, 0), 1, mk(ST_BAD, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_CLAIM_AT, 0, 1, 128, 0), 1, mk(ST_BAD, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_CLAIM_AT, 0, 0, 128, 0), 1, mk(ST_OK, 0, 0, 127, 0, 0, 0));
        add_row(mk_item(OP_CLAIM_AT, 0, 5, 1, 0), 1, mk(ST_BUSY, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_CLAIM_FIRST, 0, 0, 128, 16'h1234), 1,
                mk(ST_OK, 1, 0, 127, 0, 0, 0));
        add_row(mk_item(OP_CLAIM_FIRST, 0, 0, 255, 0), 1, mk(ST_BUSY, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_CLAIM_FIRST, 0, 0, 0, 0), 1, mk(ST_BAD, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_CLAIM_FIRST, 17, 99, 3, 16'h00a5), 0, '0);
        add_row(mk_item(OP_QUERY_AT, 31, 127, 1, 0), 1, mk(ST_BUSY, 31, 127, 127, 0, 0, 0));
        add_row(mk_item(OP_FREE_AT, 0, 3, 1, 0), 1, mk(ST_OK, 0, 0, 0, 1, 0, 0));
        add_row(mk_item(OP_FREE_AT, 0, 3, 1, 0), 1, mk(ST_BUSY, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_ROW_RUNS, 0, 0, 128, 0), 0, '0);
        add_row(mk_item(OP_ROW_RUNS, 0, 0, 1, 0), 0, '0);
        add_row(mk_item(OP_ROW_RUNS, 0, 0, 0, 0), 1, mk(ST_BAD, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_ROW_RUNS, 0, 0, 255, 0), 1, mk(ST_BUSY, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_STATS, 0, 0, 1, 0), 0, '0);
        add_row(mk_item(OP_FREE_OWNER, 0, 0, 1, 0), 0, '0);
        add_row(mk_item(OP_FREE_OWNER, 0, 0, 1, 0), 1, mk(ST_BUSY, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(OP_FREE_ALL, 0, 0, 1, 0), 0, '0);
        add_row(mk_item(OP_FREE_ALL, 0, 0, 1, 0), 1, mk(ST_BUSY, 0, 0, 0, 0, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_tab[i])
        begin
            send_op(dir_tab[i].item);
            if (dir_tab[i].typed)
            begin
                // keep the shadow grid in step, but check the typed-in answer
                predict_grid_op(dir_tab[i].item);
                void'(pending_rsp.pop_back());
                pending_rsp.push_back(dir_tab[i].want);
            end
            else
                predict_grid_op(dir_tab[i].item);
        end
        drain_results();

        // random phases; register values include out-of-range ones that clamp
        phase_rows  = '{4, 8, 1, 0, 2, 63, 5, 3};
        phase_cols  = '{16, 32, 1, 0, 130, 255, 7, 9};
        phase_items = '{25, 25, 12, 8, 20, 8, 22, 17};
        phase_mode  = '{0, 1, 2, 3, 2, 0, 3, 1};
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_ROWS, 8'(phase_rows[p]));
            write_reg(CFG_COLS, 8'(phase_cols[p]));
            cfg_valid <= 1'b0;
            idle_mode = phase_mode[p];
            if (p == 0) hold_request = 1;
            for (int n = 0; n < phase_items[p]; n++)
            begin
                it = rand_item();
                send_op(it);
                predict_grid_op(it);
            end
            drain_results();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
